// ----- hw/rtl/vrp_pkg.sv -----
// ============================================================================
// vrp_pkg: shared definitions for the vertex rotate and project core
// Holds default widths, register indexes and reset values, the quarter-wave
// sine table and the sideband struct that rides along the divider pipeline.
// ============================================================================
package vrp_pkg;

  // Default widths.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TRIG_FRAC_DEF   = 14;
  localparam int TABLE_FRAC      = 14;

  // Angle handling, in whole degrees.
  localparam int ANGLE_W     = 9;
  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = 90;
  localparam int HALF        = 180;
  localparam int THREE_Q     = 270;
  localparam int TIDX_W      = 7;

  // Configuration port.
  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

  localparam logic [CFG_W-1:0] FOCAL_RST    = 12'd100;
  localparam logic [CFG_W-1:0] DEPTH_RST    = 12'd750;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 12'd400;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 12'd225;

  // Per-beat flags carried alongside the divider stages.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic dzero;
    logic last;
  } div_side_t;

  // First quarter of round(sin * 2^14), whole degrees 0 to 90.
  function automatic logic [TABLE_FRAC:0] quarter_sine(input logic [TIDX_W-1:0] idx);
    logic [TABLE_FRAC:0] v;
    case (idx)
      7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
      7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
      7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
      7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
      7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
      7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
      7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
      7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
      7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
      7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
      7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
      7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
      7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
      7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
      7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/vertex_rotate_project_core.sv -----
// ============================================================================
// vertex_rotate_project_core: x-axis rotation with perspective projection
// Top level: configuration registers, rotation front end, pipelined divider
// and output stage.
// ============================================================================
// One vertex enters per clock whenever start is high; busy stays low, so a
// vertex is never refused. Each result appears COORD_WIDTH + 19 cycles after
// its vertex (35 cycles at 16-bit coordinates), marked by a one-cycle done
// strobe, and must be captured then: the results cannot be held off. The
// latency is set by the divider, which resolves one quotient bit per stage
// over COORD_WIDTH + 12 stages, behind six stages of rotation and set-up
// and one output stage. Configuration writes take effect at once and are
// meant to be made while no vertex is in flight.
module vertex_rotate_project_core #(
  parameter int COORD_WIDTH    = vrp_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = vrp_pkg::TRIG_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_z,
  input  logic [vrp_pkg::ANGLE_W-1:0]       angle_deg,
  input  logic                              last_in_frame,
  output logic                              done,
  output logic signed [COORD_WIDTH-1:0]     screen_x,
  output logic signed [COORD_WIDTH-1:0]     screen_y,
  output logic                              divide_error,
  output logic                              frame_end,
  input  logic                              cfg_we,
  input  logic [vrp_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [vrp_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NB = COORD_WIDTH + 12;
  localparam int DB = ((COORD_WIDTH > 12) ? COORD_WIDTH : 12) + 1;

  logic [vrp_pkg::CFG_W-1:0] focal_dist, depth_offset, center_x, center_y;
  logic                      accept;
  logic                      rot_valid, div_valid;
  logic [NB-1:0]             rot_nx, rot_ny, div_qx, div_qy;
  logic [DB-1:0]             rot_dvs;
  vrp_pkg::div_side_t        rot_side, div_side;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_dist   <= vrp_pkg::FOCAL_RST;
      depth_offset <= vrp_pkg::DEPTH_RST;
      center_x     <= vrp_pkg::CENTER_X_RST;
      center_y     <= vrp_pkg::CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vrp_pkg::REG_FOCAL:    focal_dist   <= cfg_data;
        vrp_pkg::REG_DEPTH:    depth_offset <= cfg_data;
        vrp_pkg::REG_CENTER_X: center_x     <= cfg_data;
        vrp_pkg::REG_CENTER_Y: center_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  vrp_rotate #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .NB            (NB),
    .DB            (DB)
  ) u_rotate (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .angle_deg    (angle_deg),
    .last_in_frame(last_in_frame),
    .focal_dist   (focal_dist),
    .depth_offset (depth_offset),
    .out_valid    (rot_valid),
    .num_x        (rot_nx),
    .num_y        (rot_ny),
    .dvs          (rot_dvs),
    .side         (rot_side)
  );

  vrp_divider #(
    .NB(NB),
    .DB(DB)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rot_valid),
    .num_a    (rot_nx),
    .num_b    (rot_ny),
    .dvs      (rot_dvs),
    .in_side  (rot_side),
    .out_valid(div_valid),
    .quo_a    (div_qx),
    .quo_b    (div_qy),
    .out_side (div_side)
  );

  vrp_output #(
    .COORD_WIDTH(COORD_WIDTH),
    .NB         (NB)
  ) u_output (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .quo_x       (div_qx),
    .quo_y       (div_qy),
    .side        (div_side),
    .center_x    (center_x),
    .center_y    (center_y),
    .done        (done),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .divide_error(divide_error),
    .frame_end   (frame_end)
  );

endmodule

// ----- hw/rtl/vrp_rotate.sv -----
// ============================================================================
// vrp_rotate: rotation about the x axis and projection set-up
// Six register stages: angle folding, sine and cosine lookup, products,
// rotated sums, depth and numerator products, and magnitudes with signs.
// ============================================================================
module vrp_rotate #(
  parameter int COORD_WIDTH    = vrp_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = vrp_pkg::TRIG_FRAC_DEF,
  parameter int NB             = COORD_WIDTH + 12,
  parameter int DB             = ((COORD_WIDTH > 12) ? COORD_WIDTH : 12) + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [COORD_WIDTH-1:0]   coord_x,
  input  logic signed [COORD_WIDTH-1:0]   coord_y,
  input  logic signed [COORD_WIDTH-1:0]   coord_z,
  input  logic [vrp_pkg::ANGLE_W-1:0]     angle_deg,
  input  logic                            last_in_frame,
  input  logic [vrp_pkg::CFG_W-1:0]       focal_dist,
  input  logic [vrp_pkg::CFG_W-1:0]       depth_offset,
  output logic                            out_valid,
  output logic [NB-1:0]                   num_x,
  output logic [NB-1:0]                   num_y,
  output logic [DB-1:0]                   dvs,
  output vrp_pkg::div_side_t              side
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = TRIG_FRAC_BITS;
  localparam int TW   = F + 2;
  localparam int PW   = W + F + 2;
  localparam int RW   = W + 2;
  localparam int DW   = DB + 1;
  localparam int XW   = W + 13;
  localparam int ZW   = RW + 13;
  localparam int SH_L = (F >= vrp_pkg::TABLE_FRAC) ? F - vrp_pkg::TABLE_FRAC : 0;
  localparam int SH_R = (F >= vrp_pkg::TABLE_FRAC) ? 0 : vrp_pkg::TABLE_FRAC - F;
  localparam logic [20:0] RND = (21'd1 << SH_R) >> 1;
  localparam int AW   = vrp_pkg::ANGLE_W;
  localparam int TI   = vrp_pkg::TIDX_W;

  // Folds an angle in 0..359 onto the first quarter: {negate, index}.
  function automatic logic [TI:0] fold(input logic [AW-1:0] q);
    logic [AW-1:0] t;
    logic          n;
    if (q <= AW'(vrp_pkg::QUARTER)) begin
      t = q;
      n = 1'b0;
    end else if (q <= AW'(vrp_pkg::HALF)) begin
      t = AW'(vrp_pkg::HALF) - q;
      n = 1'b0;
    end else if (q <= AW'(vrp_pkg::THREE_Q)) begin
      t = q - AW'(vrp_pkg::HALF);
      n = 1'b1;
    end else begin
      t = AW'(vrp_pkg::ANGLE_STEPS) - q;
      n = 1'b1;
    end
    return {n, t[TI-1:0]};
  endfunction

  // Table value rescaled to F fraction bits, then signed.
  function automatic logic signed [TW-1:0] trig(input logic [TI:0] fi);
    logic [20:0]   m;
    logic [F:0]    mag;
    m   = {6'd0, vrp_pkg::quarter_sine(fi[TI-1:0])};
    m   = ((m + RND) >> SH_R) << SH_L;
    mag = m[F:0];
    return fi[TI] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Stage 1: wrap the angle and fold sine and cosine angles.
  logic [AW-1:0]         ang_w;
  logic [AW:0]           cang;
  logic [AW-1:0]         cang_w;
  logic                  s1_valid, s1_last;
  logic [TI:0]           s1_sf, s1_cf;
  logic signed [W-1:0]   s1_x, s1_y, s1_z;

  always_comb begin
    ang_w  = (angle_deg >= AW'(vrp_pkg::ANGLE_STEPS)) ?
             angle_deg - AW'(vrp_pkg::ANGLE_STEPS) : angle_deg;
    cang   = {1'b0, ang_w} + (AW+1)'(vrp_pkg::QUARTER);
    cang_w = (cang >= (AW+1)'(vrp_pkg::ANGLE_STEPS)) ?
             AW'(cang - (AW+1)'(vrp_pkg::ANGLE_STEPS)) : cang[AW-1:0];
  end

  always_ff @(posedge clk) begin
    s1_sf   <= fold(ang_w);
    s1_cf   <= fold(cang_w);
    s1_x    <= coord_x;
    s1_y    <= coord_y;
    s1_z    <= coord_z;
    s1_last <= last_in_frame;
  end

  // Stage 2: sine and cosine lookup.
  logic                  s2_valid, s2_last;
  logic signed [TW-1:0]  s2_sin, s2_cos;
  logic signed [W-1:0]   s2_x, s2_y, s2_z;

  always_ff @(posedge clk) begin
    s2_sin  <= trig(s1_sf);
    s2_cos  <= trig(s1_cf);
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_z    <= s1_z;
    s2_last <= s1_last;
  end

  // Stage 3: the four rotation products.
  logic                  s3_valid, s3_last;
  logic signed [PW-1:0]  s3_yc, s3_zs, s3_ys, s3_zc;
  logic signed [W-1:0]   s3_x;

  always_ff @(posedge clk) begin
    s3_yc   <= s2_y * s2_cos;
    s3_zs   <= s2_z * s2_sin;
    s3_ys   <= s2_y * s2_sin;
    s3_zc   <= s2_z * s2_cos;
    s3_x    <= s2_x;
    s3_last <= s2_last;
  end

  // Stage 4: rotated sums, scaled down with truncation toward zero.
  logic signed [PW:0]    sum_y, sum_z, adj_y, adj_z;
  logic                  s4_valid, s4_last;
  logic signed [RW-1:0]  s4_ry, s4_rz;
  logic signed [W-1:0]   s4_x;

  always_comb begin
    sum_y = (PW+1)'(s3_yc) - (PW+1)'(s3_zs);
    sum_z = (PW+1)'(s3_ys) + (PW+1)'(s3_zc);
    adj_y = sum_y + $signed({{(PW+1-F){1'b0}}, {F{sum_y[PW]}}});
    adj_z = sum_z + $signed({{(PW+1-F){1'b0}}, {F{sum_z[PW]}}});
  end

  always_ff @(posedge clk) begin
    s4_ry   <= adj_y[F+RW-1:F];
    s4_rz   <= adj_z[F+RW-1:F];
    s4_x    <= s3_x;
    s4_last <= s3_last;
  end

  // Stage 5: shifted depth and the numerator products.
  logic                  s5_valid, s5_last;
  logic signed [DW-1:0]  s5_d;
  logic signed [XW-1:0]  s5_nx;
  logic signed [ZW-1:0]  s5_nz;
  logic signed [12:0]    f_s;

  assign f_s = $signed({1'b0, focal_dist});

  always_ff @(posedge clk) begin
    s5_d    <= DW'(s4_ry) + DW'(f_s) - DW'($signed({1'b0, depth_offset}));
    s5_nx   <= s4_x * f_s;
    s5_nz   <= s4_rz * f_s;
    s5_last <= s4_last;
  end

  // Stage 6: magnitudes for the unsigned divider and quotient signs.
  logic [XW-1:0] abs_x;
  logic [ZW-1:0] abs_z;
  logic [DW-1:0] abs_d;

  always_comb begin
    abs_x = s5_nx[XW-1] ? XW'(-s5_nx) : XW'(s5_nx);
    abs_z = s5_nz[ZW-1] ? ZW'(-s5_nz) : ZW'(s5_nz);
    abs_d = s5_d[DW-1] ? DW'(-s5_d) : DW'(s5_d);
  end

  always_ff @(posedge clk) begin
    num_x      <= abs_x[NB-1:0];
    num_y      <= abs_z[NB-1:0];
    dvs        <= abs_d[DB-1:0];
    side.neg_x <= s5_nx[XW-1] ^ s5_d[DW-1];
    side.neg_y <= s5_nz[ZW-1] ^ s5_d[DW-1];
    side.dzero <= (s5_d == '0);
    side.last  <= s5_last;
  end

  // Valid bits travel with the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

endmodule

// ----- hw/rtl/vrp_divider.sv -----
// ============================================================================
// vrp_divider: pipelined restoring divider, two dividends, one divisor
// One quotient bit per stage for both dividends; a new beat may enter
// every cycle.
// ============================================================================
module vrp_divider #(
  parameter int NB = 28,
  parameter int DB = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [NB-1:0]      num_a,
  input  logic [NB-1:0]      num_b,
  input  logic [DB-1:0]      dvs,
  input  vrp_pkg::div_side_t in_side,
  output logic               out_valid,
  output logic [NB-1:0]      quo_a,
  output logic [NB-1:0]      quo_b,
  output vrp_pkg::div_side_t out_side
);

  // Stage registers; index k holds the beat after k quotient bits.
  logic [DB-1:0]      rem_a [1:NB];
  logic [DB-1:0]      rem_b [1:NB];
  logic [NB-1:0]      nq_a  [1:NB];
  logic [NB-1:0]      nq_b  [1:NB];
  logic [DB-1:0]      dv    [1:NB];
  vrp_pkg::div_side_t sd    [1:NB];
  logic               vld   [1:NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DB-1:0]      ra, rb, dc;
    logic [NB-1:0]      qa, qb;
    vrp_pkg::div_side_t sc;
    logic               vc;
    logic [DB:0]        ta, tb, da, db;
    logic               ga, gb;

    // Beat entering this stage.
    if (k == 0) begin : g_first
      assign ra = '0;
      assign rb = '0;
      assign qa = num_a;
      assign qb = num_b;
      assign dc = dvs;
      assign sc = in_side;
      assign vc = in_valid;
    end else begin : g_next
      assign ra = rem_a[k];
      assign rb = rem_b[k];
      assign qa = nq_a[k];
      assign qb = nq_b[k];
      assign dc = dv[k];
      assign sc = sd[k];
      assign vc = vld[k];
    end

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
      ta = {ra, qa[NB-1]};
      tb = {rb, qb[NB-1]};
      ga = (ta >= {1'b0, dc});
      gb = (tb >= {1'b0, dc});
      da = ta - {1'b0, dc};
      db = tb - {1'b0, dc};
    end

    always_ff @(posedge clk) begin
      rem_a[k+1] <= ga ? da[DB-1:0] : ta[DB-1:0];
      rem_b[k+1] <= gb ? db[DB-1:0] : tb[DB-1:0];
      nq_a[k+1]  <= {qa[NB-2:0], ga};
      nq_b[k+1]  <= {qb[NB-2:0], gb};
      dv[k+1]    <= dc;
      sd[k+1]    <= sc;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vc;
      end
    end
  end

  assign out_valid = vld[NB];
  assign quo_a     = nq_a[NB];
  assign quo_b     = nq_b[NB];
  assign out_side  = sd[NB];

endmodule

// ----- hw/rtl/vrp_output.sv -----
// ============================================================================
// vrp_output: sign, screen offset and saturation
// Restores the quotient signs, adds the screen center and clamps to the
// signed coordinate range; forces zero outputs on a zero divisor.
// ============================================================================
module vrp_output #(
  parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
  parameter int NB          = COORD_WIDTH + 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [NB-1:0]                 quo_x,
  input  logic [NB-1:0]                 quo_y,
  input  vrp_pkg::div_side_t            side,
  input  logic [vrp_pkg::CFG_W-1:0]     center_x,
  input  logic [vrp_pkg::CFG_W-1:0]     center_y,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] screen_x,
  output logic signed [COORD_WIDTH-1:0] screen_y,
  output logic                          divide_error,
  output logic                          frame_end
);

  localparam int W  = COORD_WIDTH;
  localparam int SW = NB + 2;
  localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [W-1:0]  sat_x, sat_y;

  // Signed quotient plus the screen center.
  always_comb begin
    sum_x = (side.neg_x ? -SW'($signed({1'b0, quo_x})) : SW'($signed({1'b0, quo_x})))
            + SW'($signed({1'b0, center_x}));
    sum_y = (side.neg_y ? -SW'($signed({1'b0, quo_y})) : SW'($signed({1'b0, quo_y})))
            + SW'($signed({1'b0, center_y}));
    sat_x = (sum_x > MAXV) ? MAXV[W-1:0] : (sum_x < MINV) ? MINV[W-1:0] : sum_x[W-1:0];
    sat_y = (sum_y > MAXV) ? MAXV[W-1:0] : (sum_y < MINV) ? MINV[W-1:0] : sum_y[W-1:0];
  end

  // Result beat strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Result payload, zero outside a result beat.
  always_ff @(posedge clk) begin
    screen_x     <= (in_valid && !side.dzero) ? sat_x : '0;
    screen_y     <= (in_valid && !side.dzero) ? sat_y : '0;
    divide_error <= in_valid && side.dzero;
    frame_end    <= in_valid && side.last;
  end

endmodule

// ----- hw/rtl/vrp_checker.sv -----
// ============================================================================
// vrp_checker: port-level checks for the vertex rotate and project core
// Watches the result beat, its latency and reset behavior on the top-level
// ports.
// ============================================================================
module vrp_checker #(
  parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] screen_x,
  input logic signed [COORD_WIDTH-1:0] screen_y,
  input logic                          divide_error,
  input logic                          frame_end
);

  // A zero divisor gives zero coordinates.
  a_dzero_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_error |-> screen_x == '0 && screen_y == '0)
    else $error("divide error beat with nonzero coordinates");

  // Flags show only on a result beat.
  a_flags_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> !divide_error && !frame_end)
    else $error("result flag outside a result beat");

  // Reset flushes every beat in flight.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

  // Every accepted vertex gives its result beat after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(COORD_WIDTH + 19) done)
    else $error("result beat missing after an accepted vertex");

endmodule

bind vertex_rotate_project_core vrp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vrp_checker (.*);

// ----- tb/vertex_projection_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vertex_projection_checker: result predictor and scoreboard
// Watches the register writes, the accepted vertex beats and the result
// strobes of the vertex rotate and project core. It works out each screen
// position on its own and compares every result beat with the oldest one.
// ============================================================================
module vertex_projection_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [8:0]         angle_deg,
  input  logic               last_in_frame,
  input  logic               done,
  input  logic signed [15:0] screen_x,
  input  logic signed [15:0] screen_y,
  input  logic               divide_error,
  input  logic               frame_end,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen,
  output int                 zero_divisors,
  output int                 saturations
);

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               derr;
    logic               fend;
  } screen_point_t;

  // round(sin * 2^14) over the first quarter wave.
  localparam int SINE_Q [0:90] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384};

  logic [11:0] focal, depth, cen_x, cen_y;
  screen_point_t projected_q[$];

  // Sine of a whole-degree angle, built from the quarter wave by symmetry.
  function automatic longint sine_of(int deg);
    int q;
    q = deg % 360;
    if (q <= 90) return SINE_Q[q];
    if (q <= 180) return SINE_Q[180 - q];
    if (q <= 270) return -SINE_Q[q - 180];
    return -SINE_Q[360 - q];
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Rotation about x, depth shift and perspective divide for one vertex.
  function automatic screen_point_t project_vertex(
      longint x, longint y, longint z, int ang, logic last);
    screen_point_t p;
    longint s, c, ry, rz, f, d, vx, vy;
    s  = sine_of(ang % 360);
    c  = sine_of(ang % 360 + 90);
    ry = (y * c - z * s) / 16384;
    rz = (y * s + z * c) / 16384;
    f  = longint'(focal);
    d  = f + (ry - longint'(depth));
    p.fend = last;
    if (d == 0) begin
      p.sx = '0;
      p.sy = '0;
      p.derr = 1'b1;
    end else begin
      vx = (x * f) / d + longint'(cen_x);
      vy = (rz * f) / d + longint'(cen_y);
      p.sx = clamp16(vx);
      p.sy = clamp16(vy);
      p.derr = 1'b0;
    end
    return p;
  endfunction

  assign pending = projected_q.size();

  // Register shadow, prediction on every accepted beat, compare on every strobe.
  always @(posedge clk) begin
    screen_point_t e, p;
    if (rst) begin
      focal <= vrp_pkg::FOCAL_RST;
      depth <= vrp_pkg::DEPTH_RST;
      cen_x <= vrp_pkg::CENTER_X_RST;
      cen_y <= vrp_pkg::CENTER_Y_RST;
      projected_q.delete();
      mismatches <= 0;
      results_seen <= 0;
      zero_divisors <= 0;
      saturations <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vrp_pkg::REG_FOCAL:    focal <= cfg_data;
          vrp_pkg::REG_DEPTH:    depth <= cfg_data;
          vrp_pkg::REG_CENTER_X: cen_x <= cfg_data;
          vrp_pkg::REG_CENTER_Y: cen_y <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        p = project_vertex(longint'(coord_x), longint'(coord_y), longint'(coord_z),
                           int'(angle_deg), last_in_frame);
        if (p.derr) zero_divisors <= zero_divisors + 1;
        if (!p.derr && (p.sx == 16'sh7fff || p.sx == -16'sh8000 ||
                        p.sy == 16'sh7fff || p.sy == -16'sh8000))
          saturations <= saturations + 1;
        projected_q.push_back(p);
      end
      if (done) begin
        results_seen <= results_seen + 1;
        if (projected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: sx %0d sy %0d err %b end %b",
                   $time, screen_x, screen_y, divide_error, frame_end);
          mismatches <= mismatches + 1;
        end else begin
          e = projected_q.pop_front();
          if (screen_x !== e.sx || screen_y !== e.sy || divide_error !== e.derr ||
              frame_end !== e.fend) begin
            $display("%0t: mismatch: expected sx %0d sy %0d err %b end %b",
                     $time, e.sx, e.sy, e.derr, e.fend);
            $display("%0t:           actual   sx %0d sy %0d err %b end %b",
                     $time, screen_x, screen_y, divide_error, frame_end);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/vertex_rotate_project_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vertex_rotate_project_core_tb: testbench top for the vertex projection core
// Drives directed and random vertices through several register settings and
// sender idle patterns; the checker predicts and compares each result.
// ============================================================================
module vertex_rotate_project_core_tb;

  localparam int SETTLE_CYCLES = 45;
  localparam int CYCLE_LIMIT   = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [8:0]         angle_deg = '0;
  logic               last_in_frame = 1'b0;
  logic               done;
  logic signed [15:0] screen_x, screen_y;
  logic               divide_error, frame_end;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;
  int                 mismatches, pending, results_seen, zero_divisors, saturations;
  int                 cycles = 0;
  int                 idle_pct = 0;
  int                 vertices_sent = 0;
  logic [11:0]        cur_focal = vrp_pkg::FOCAL_RST, cur_depth = vrp_pkg::DEPTH_RST;

  vertex_rotate_project_core uut (.*);
  vertex_projection_checker chk (.*);

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One vertex beat, with a random idle stretch ahead of it.
  task automatic send_vertex(int x, int y, int z, int ang, logic last);
    logic ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coord_x <= x[15:0];
    coord_y <= y[15:0];
    coord_z <= z[15:0];
    angle_deg <= ang[8:0];
    last_in_frame <= last;
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
    vertices_sent++;
  endtask

  // Wait for the core to drain, then load all four registers.
  task automatic load_registers(logic [11:0] f, logic [11:0] d, logic [11:0] cx,
                                logic [11:0] cy);
    logic [11:0] vals [4];
    start <= 1'b0;
    vals = '{f, d, cx, cy};
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_focal = f;
    cur_depth = d;
  endtask

  // Half modest vertices; the rest full range, close to a zero divisor, or at angles of 360 and up.
  task automatic random_vertices(int count);
    int x, y, z, ang, sel, sing;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      x = int'($urandom_range(4000)) - 2000;
      y = int'($urandom_range(4000)) - 2000;
      z = int'($urandom_range(4000)) - 2000;
      ang = $urandom_range(359);
      if (sel < 25) begin
        x = int'($urandom_range(65535)) - 32768;
        y = int'($urandom_range(65535)) - 32768;
        z = int'($urandom_range(65535)) - 32768;
      end else if (sel < 40) begin
        // At 0 or 180 degrees the depth is +y or -y, so aim at d near zero.
        sing = int'(cur_depth) - int'(cur_focal) + int'($urandom_range(4)) - 2;
        ang = $urandom_range(1) ? 180 : 0;
        y = (ang == 0) ? sing : -sing;
        z = int'($urandom_range(65535)) - 32768;
        x = int'($urandom_range(65535)) - 32768;
      end else if (sel < 50) begin
        ang = $urandom_range(511, 360);
        x = int'($urandom_range(65535)) - 32768;
        z = int'($urandom_range(65535)) - 32768;
      end
      send_vertex(x, y, z, ang, ($urandom_range(7) == 0));
    end
  endtask

  initial begin
    int idle_by_phase [6];
    idle_by_phase = '{0, 87, 29, 0, 87, 29};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed vertices under the reset register values.
    send_vertex(32767, 0, 0, 0, 1'b0);
    send_vertex(-32768, 0, 0, 0, 1'b1);
    send_vertex(100, 32767, -32768, 90, 1'b0);
    send_vertex(-100, -32768, 32767, 180, 1'b1);
    send_vertex(500, 1000, 2000, 270, 1'b0);
    send_vertex(7, -7, 7, 359, 1'b0);
    send_vertex(123, 456, -789, 360, 1'b1);
    send_vertex(-32768, -32768, -32768, 511, 1'b1);
    send_vertex(32767, 32767, 32767, 450, 1'b0);
    send_vertex(300, 650, 1234, 0, 1'b1);      // zero divisor
    send_vertex(-300, -650, 99, 180, 1'b0);    // zero divisor, rotated half turn
    send_vertex(32767, 651, 32767, 0, 1'b0);   // divisor of one saturates high
    send_vertex(-32768, 651, -32768, 0, 1'b1); // and low
    send_vertex(0, 0, 0, 45, 1'b0);
    send_vertex(1, -1, 1, 135, 1'b0);
    send_vertex(0, 649, 0, 0, 1'b0);           // divisor of minus one
    random_vertices(120);

    // Register settings from one extreme to the other, then random ones.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_registers(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        1: load_registers(12'd1, 12'd0, 12'd0, 12'd0);
        2: load_registers(12'd0, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                          12'($urandom_range(4095)));
        default: load_registers(12'($urandom_range(4095, 1)), 12'($urandom_range(4095)),
                                12'($urandom_range(4095)), 12'($urandom_range(4095)));
      endcase
      idle_pct = idle_by_phase[ph];
      send_vertex(32767, int'(cur_depth) - int'(cur_focal), -32768, 0, 1'b1);
      random_vertices(105);
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d vertices under 7 register settings; %0d results checked.",
             vertices_sent, results_seen);
    $display("Zero divisors: %0d, saturated results: %0d, mismatches: %0d.",
             zero_divisors, saturations, mismatches);
    if (mismatches == 0 && results_seen == vertices_sent) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
